// ----- design/border_clipped_median_filter_defines.svh -----
// assertion macros for the border clipped median filter
// used by the controller; no other dependencies
`ifndef BORDER_CLIPPED_MEDIAN_FILTER_DEFINES_SVH
`define BORDER_CLIPPED_MEDIAN_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BCMF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcmf assertion failed");
// next-cycle implication
`define BCMF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcmf assertion failed");
`else
`define BCMF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BCMF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/bcmf_pkg.sv -----
// shared types and constants of the border clipped median filter
// no dependencies
`default_nettype none
package bcmf_pkg;

   // parameter defaults
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_RADIUS_DEF   = 2;
   localparam int MAX_CHANNELS_DEF = 3;

   // fixed field widths
   localparam int SAMPLE_W  = 8;
   localparam int ROW_W     = 12;
   localparam int OUT_COL_W = 10;
   localparam int CHAN_W    = 2;
   localparam int CFG_W_W   = 11;
   localparam int CFG_H_W   = 13;
   localparam int CFG_C_W   = 2;
   localparam int CFG_R_W   = 2;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   typedef enum logic [1:0] {
      REG_WIDTH    = 2'd0,
      REG_HEIGHT   = 2'd1,
      REG_CHANNELS = 2'd2,
      REG_RADIUS   = 2'd3
   } reg_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINIT,
      ST_READ,
      ST_INSERT,
      ST_EMIT
   } state_type;

   // commands to the datapath
   typedef struct packed {
      logic accept;
      logic win_init;
      logic rd;
      logic ins;
      logic next_out;
   } cmd_type;

   // status from the datapath
   typedef struct packed {
      logic has_out;
      logic rd_last;
      logic out_last;
   } status_type;

endpackage
`default_nettype wire

// ----- design/bcmf_if.sv -----
// item channel interfaces of the median filter
// depends on bcmf_pkg
`default_nettype none
interface bcmf_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcmf_pkg::SAMPLE_W-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface bcmf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bcmf_pkg::SAMPLE_W-1:0]  median_value;
   logic [bcmf_pkg::ROW_W-1:0]     out_row;
   logic [bcmf_pkg::OUT_COL_W-1:0] out_column;
   logic [bcmf_pkg::CHAN_W-1:0]    out_channel;
   logic                           last_in_run;
   modport source (output valid, output median_value, output out_row, output out_column,
                   output out_channel, output last_in_run, input ready);
   modport sink (input valid, input median_value, input out_row, input out_column,
                 input out_channel, input last_in_run, output ready);
endinterface
`default_nettype wire

// ----- design/bcmf_ram.sv -----
// generic single port ram with registered read
// no dependencies
`default_nettype none
module bcmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- design/bcmf_ctrl.sv -----
// controller state machine of the median filter
// depends on bcmf_pkg and the defines header
`default_nettype none
`include "border_clipped_median_filter_defines.svh"
module bcmf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bcmf_pkg::status_type status,
   output bcmf_pkg::cmd_type         cmd
);
   bcmf_pkg::state_type state_ff, state_in;
   logic in_idle, in_read, in_insert, in_emit;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bcmf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.has_out) begin
                  state_in = bcmf_pkg::ST_WINIT;
               end
            end
         end
         bcmf_pkg::ST_WINIT: begin
            cmd.win_init = 1'b1;
            state_in     = bcmf_pkg::ST_READ;
         end
         bcmf_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = bcmf_pkg::ST_INSERT;
         end
         bcmf_pkg::ST_INSERT: begin
            cmd.ins  = 1'b1;
            state_in = status.rd_last ? bcmf_pkg::ST_EMIT : bcmf_pkg::ST_READ;
         end
         bcmf_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.out_last) begin
                  state_in = bcmf_pkg::ST_IDLE;
               end else begin
                  cmd.next_out = 1'b1;
                  state_in     = bcmf_pkg::ST_WINIT;
               end
            end
         end
         default: begin
            state_in = bcmf_pkg::ST_IDLE;
         end
      endcase
   end

   // state decodes for the checks
   assign in_idle   = (state_ff == bcmf_pkg::ST_IDLE);
   assign in_read   = (state_ff == bcmf_pkg::ST_READ);
   assign in_insert = (state_ff == bcmf_pkg::ST_INSERT);
   assign in_emit   = (state_ff == bcmf_pkg::ST_EMIT);

   // a sample without results leaves the controller idle
   `BCMF_ASSERT_NXT(a_no_out_idle, clock, reset, in_idle && req_valid && !status.has_out, in_idle)
   // every read is followed by its insert
   `BCMF_ASSERT_NXT(a_read_insert, clock, reset, in_read, in_insert)
   // a stalled result stays offered
   `BCMF_ASSERT_NXT(a_emit_hold, clock, reset, in_emit && !rsp_ready, in_emit)
endmodule
`default_nettype wire

// ----- design/bcmf_datapath.sv -----
// datapath: config registers, counters, line store, window walk and sorter
// depends on bcmf_pkg and bcmf_ram
`default_nettype none
module bcmf_datapath #(
   parameter int MAX_WIDTH    = bcmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS   = bcmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_CHANNELS = bcmf_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bcmf_pkg::cmd_type                cmd,
   output bcmf_pkg::status_type                  status,
   input  wire logic [bcmf_pkg::SAMPLE_W-1:0]    sample_in,
   output logic      [bcmf_pkg::SAMPLE_W-1:0]    median_value,
   output logic      [bcmf_pkg::ROW_W-1:0]       out_row,
   output logic      [bcmf_pkg::OUT_COL_W-1:0]   out_column,
   output logic      [bcmf_pkg::CHAN_W-1:0]      out_channel,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bcmf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [bcmf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [bcmf_pkg::CSR_DATA_W-1:0]  csr_prdata
);
   localparam int RING  = 2 * MAX_RADIUS + 1;
   localparam int DEPTH = RING * MAX_WIDTH * MAX_CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int SW    = $clog2(RING);
   localparam int WIN   = RING * RING;
   localparam int NW    = $clog2(WIN + 1);
   localparam int IW    = $clog2(WIN);
   localparam int RW    = bcmf_pkg::ROW_W;
   localparam int HW    = bcmf_pkg::CFG_H_W;

   // config registers
   logic [bcmf_pkg::CFG_W_W-1:0] cfg_w_ff, cfg_w_in;
   logic [bcmf_pkg::CFG_H_W-1:0] cfg_h_ff, cfg_h_in;
   logic [bcmf_pkg::CFG_C_W-1:0] cfg_c_ff, cfg_c_in;
   logic [bcmf_pkg::CFG_R_W-1:0] cfg_r_ff, cfg_r_in;
   // stream position
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [1:0]        chan_ff, chan_in;
   logic [SW-1:0]     slot_ff, slot_in;
   // latched trigger sample
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [1:0]        cur_chan_ff, cur_chan_in;
   logic [SW-1:0]     cur_slot_ff, cur_slot_in;
   // result walk
   logic [RW-1:0]     oi_ff, oi_in, i1_ff, i1_in;
   logic [CW-1:0]     oj_ff, oj_in, j0_ff, j0_in, j1_ff, j1_in;
   // window walk
   logic [RW-1:0]     m_ff, m_in, r1_ff, r1_in;
   logic [CW-1:0]     q_ff, q_in, c0_ff, c0_in, c1_ff, c1_in;
   logic              rd_last_ff, rd_last_in;
   // sorter
   logic [7:0]        vals_ff [WIN];
   logic [7:0]        vals_in [WIN];
   logic [NW-1:0]     n_ff, n_in;
   logic              lt [WIN];

   // effective config and helpers
   logic [WW-1:0]     eff_w, wm1;
   logic [HW-1:0]     eff_h, hm1;
   logic [1:0]        eff_c;
   logic [1:0]        eff_r;
   logic [31:0]       w32, j32, waddr32, raddr32;
   logic              cfg_we;
   logic [HW-1:0]     row13, ti0, ti1;
   logic [WW-1:0]     colw, tj0, tj1;
   logic              row_ok, col_ok;
   logic [HW-1:0]     wi13, wr0, wr1;
   logic [WW:0]       wj, wc0, wc1;
   logic [RW-1:0]     diff;
   logic [SW:0]       slot_sum;
   logic [SW-1:0]     rslot;
   logic [AW-1:0]     ram_addr;
   logic [7:0]        ram_rdata;
   logic [7:0]        v;

   assign cfg_we = csr_psel && csr_penable && csr_pwrite;

   // clamp the config registers
   always_comb begin
      w32 = 32'(cfg_w_ff);
      if (w32 == 32'd0) begin
         eff_w = WW'(1);
      end else if (w32 > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = w32[WW-1:0];
      end
      if (cfg_h_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(cfg_h_ff) > 32'(bcmf_pkg::MAX_HEIGHT)) begin
         eff_h = HW'(bcmf_pkg::MAX_HEIGHT);
      end else begin
         eff_h = cfg_h_ff;
      end
      if (cfg_c_ff == '0) begin
         eff_c = 2'd1;
      end else if (32'(cfg_c_ff) > 32'(MAX_CHANNELS)) begin
         eff_c = 2'(MAX_CHANNELS);
      end else begin
         eff_c = cfg_c_ff;
      end
      if (32'(cfg_r_ff) > 32'(MAX_RADIUS)) begin
         eff_r = 2'(MAX_RADIUS);
      end else begin
         eff_r = cfg_r_ff;
      end
      wm1 = eff_w - WW'(1);
      hm1 = eff_h - HW'(1);
   end

   // trigger range of the current sample
   always_comb begin
      row13  = {1'b0, row_ff};
      row_ok = 1'b1;
      if (row13 == hm1) begin
         ti1 = hm1;
         ti0 = (hm1 >= HW'(eff_r)) ? hm1 - HW'(eff_r) : '0;
      end else if (row13 >= HW'(eff_r)) begin
         ti0 = row13 - HW'(eff_r);
         ti1 = ti0;
      end else begin
         ti0    = '0;
         ti1    = '0;
         row_ok = 1'b0;
      end
      colw   = WW'(col_ff);
      col_ok = 1'b1;
      if (colw == wm1) begin
         tj1 = wm1;
         tj0 = (wm1 >= WW'(eff_r)) ? wm1 - WW'(eff_r) : '0;
      end else if (colw >= WW'(eff_r)) begin
         tj0 = colw - WW'(eff_r);
         tj1 = tj0;
      end else begin
         tj0    = '0;
         tj1    = '0;
         col_ok = 1'b0;
      end
   end

   // clipped window of the current result
   always_comb begin
      wi13 = {1'b0, oi_ff};
      wr0  = (wi13 >= HW'(eff_r)) ? wi13 - HW'(eff_r) : '0;
      wr1  = (wi13 + HW'(eff_r) <= hm1) ? wi13 + HW'(eff_r) : hm1;
      wj   = (WW + 1)'(oj_ff);
      wc0  = (wj >= (WW + 1)'(eff_r)) ? wj - (WW + 1)'(eff_r) : '0;
      wc1  = (wj + (WW + 1)'(eff_r) <= {1'b0, wm1}) ? wj + (WW + 1)'(eff_r) : {1'b0, wm1};
   end

   // line store addresses
   always_comb begin
      diff     = cur_row_ff - m_ff;
      slot_sum = (SW + 1)'(cur_slot_ff) + (SW + 1)'(RING) - (SW + 1)'(diff);
      if (slot_sum >= (SW + 1)'(RING)) begin
         slot_sum = slot_sum - (SW + 1)'(RING);
      end
      rslot   = slot_sum[SW-1:0];
      waddr32 = (32'(slot_ff) * 32'(MAX_WIDTH) + 32'(col_ff)) * 32'(MAX_CHANNELS)
                + 32'(chan_ff);
      raddr32 = (32'(rslot) * 32'(MAX_WIDTH) + 32'(q_ff)) * 32'(MAX_CHANNELS)
                + 32'(cur_chan_ff);
      ram_addr = cmd.accept ? waddr32[AW-1:0] : raddr32[AW-1:0];
   end

   bcmf_ram #(
      .WIDTH (bcmf_pkg::SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (cmd.accept),
      .addr  (ram_addr),
      .wdata (sample_in),
      .rdata (ram_rdata)
   );

   // next state of all registers
   always_comb begin
      cfg_w_in    = cfg_w_ff;
      cfg_h_in    = cfg_h_ff;
      cfg_c_in    = cfg_c_ff;
      cfg_r_in    = cfg_r_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      chan_in     = chan_ff;
      slot_in     = slot_ff;
      cur_row_in  = cur_row_ff;
      cur_chan_in = cur_chan_ff;
      cur_slot_in = cur_slot_ff;
      oi_in       = oi_ff;
      i1_in       = i1_ff;
      oj_in       = oj_ff;
      j0_in       = j0_ff;
      j1_in       = j1_ff;
      m_in        = m_ff;
      r1_in       = r1_ff;
      q_in        = q_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      rd_last_in  = rd_last_ff;
      n_in        = n_ff;
      v           = ram_rdata;

      // accept: latch the sample position and step the counters
      if (cmd.accept) begin
         cur_row_in  = row_ff;
         cur_chan_in = chan_ff;
         cur_slot_in = slot_ff;
         oi_in       = ti0[RW-1:0];
         i1_in       = ti1[RW-1:0];
         oj_in       = tj0[CW-1:0];
         j0_in       = tj0[CW-1:0];
         j1_in       = tj1[CW-1:0];
         if (chan_ff + 2'd1 >= eff_c) begin
            chan_in = '0;
            if (WW'(col_ff) + WW'(1) >= eff_w) begin
               col_in = '0;
               if (HW'(row_ff) + HW'(1) >= eff_h) begin
                  row_in  = '0;
                  slot_in = '0;
               end else begin
                  row_in  = row_ff + RW'(1);
                  slot_in = (slot_ff == SW'(RING - 1)) ? '0 : slot_ff + SW'(1);
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end else begin
            chan_in = chan_ff + 2'd1;
         end
      end

      // start the window of the current result
      if (cmd.win_init) begin
         m_in  = wr0[RW-1:0];
         r1_in = wr1[RW-1:0];
         q_in  = wc0[CW-1:0];
         c0_in = wc0[CW-1:0];
         c1_in = wc1[CW-1:0];
         n_in  = '0;
      end

      // walk the window in raster order
      if (cmd.rd) begin
         rd_last_in = (m_ff == r1_ff) && (q_ff == c1_ff);
         if (q_ff == c1_ff) begin
            q_in = c0_ff;
            m_in = m_ff + RW'(1);
         end else begin
            q_in = q_ff + CW'(1);
         end
      end

      // step to the next result
      if (cmd.next_out) begin
         if (oj_ff == j1_ff) begin
            oj_in = j0_ff;
            oi_in = oi_ff + RW'(1);
         end else begin
            oj_in = oj_ff + CW'(1);
         end
      end

      // sorted insert of the read value
      for (int k = 0; k < WIN; k++) begin
         lt[k] = (NW'(k) < n_ff) && (vals_ff[k] <= v);
      end
      vals_in[0] = (cmd.ins && !lt[0]) ? v : vals_ff[0];
      for (int k = 1; k < WIN; k++) begin
         if (!cmd.ins || lt[k]) begin
            vals_in[k] = vals_ff[k];
         end else if (lt[k-1]) begin
            vals_in[k] = v;
         end else begin
            vals_in[k] = vals_ff[k-1];
         end
      end
      if (cmd.ins) begin
         n_in = n_ff + NW'(1);
      end

      // config writes restart the image
      if (cfg_we) begin
         case (bcmf_pkg::reg_index_type'(csr_paddr[3:2]))
            bcmf_pkg::REG_WIDTH:    cfg_w_in = csr_pwdata[bcmf_pkg::CFG_W_W-1:0];
            bcmf_pkg::REG_HEIGHT:   cfg_h_in = csr_pwdata[bcmf_pkg::CFG_H_W-1:0];
            bcmf_pkg::REG_CHANNELS: cfg_c_in = csr_pwdata[bcmf_pkg::CFG_C_W-1:0];
            bcmf_pkg::REG_RADIUS:   cfg_r_in = csr_pwdata[bcmf_pkg::CFG_R_W-1:0];
            default:                cfg_w_in = cfg_w_ff;
         endcase
         row_in  = '0;
         col_in  = '0;
         chan_in = '0;
         slot_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= bcmf_pkg::CFG_W_W'(512);
         cfg_h_ff <= bcmf_pkg::CFG_H_W'(512);
         cfg_c_ff <= bcmf_pkg::CFG_C_W'(3);
         cfg_r_ff <= bcmf_pkg::CFG_R_W'(1);
         row_ff   <= '0;
         col_ff   <= '0;
         chan_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
         cfg_c_ff <= cfg_c_in;
         cfg_r_ff <= cfg_r_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         chan_ff  <= chan_in;
         slot_ff  <= slot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_row_ff  <= cur_row_in;
      cur_chan_ff <= cur_chan_in;
      cur_slot_ff <= cur_slot_in;
      oi_ff       <= oi_in;
      i1_ff       <= i1_in;
      oj_ff       <= oj_in;
      j0_ff       <= j0_in;
      j1_ff       <= j1_in;
      m_ff        <= m_in;
      r1_ff       <= r1_in;
      q_ff        <= q_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      rd_last_ff  <= rd_last_in;
      n_ff        <= n_in;
      vals_ff     <= vals_in;
   end

   // register read back
   always_comb begin
      case (bcmf_pkg::reg_index_type'(csr_paddr[3:2]))
         bcmf_pkg::REG_WIDTH:    csr_prdata = 32'(cfg_w_ff);
         bcmf_pkg::REG_HEIGHT:   csr_prdata = 32'(cfg_h_ff);
         bcmf_pkg::REG_CHANNELS: csr_prdata = 32'(cfg_c_ff);
         bcmf_pkg::REG_RADIUS:   csr_prdata = 32'(cfg_r_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // status and result fields
   always_comb begin
      status.has_out  = row_ok && col_ok;
      status.rd_last  = rd_last_ff;
      status.out_last = (oi_ff == i1_ff) && (oj_ff == j1_ff);
      median_value    = vals_ff[IW'(n_ff >> 1)];
      out_row         = oi_ff;
      j32             = 32'(oj_ff);
      out_column      = j32[bcmf_pkg::OUT_COL_W-1:0];
      out_channel     = cur_chan_ff;
   end
endmodule
`default_nettype wire

// ----- design/border_clipped_median_filter.sv -----
// top level of the border clipped median filter
// depends on bcmf_pkg, bcmf_if, bcmf_ctrl, bcmf_datapath
//
//   channel   direction  handshake        payload
//   req_chan  in         valid/ready      sample_in
//   rsp_chan  out        valid/ready      median_value, out_row, out_column,
//                                          out_channel, last_in_run
//   csr_*     in/out     apb, pready=1    four config registers at 0,4,8,12
//
// a sample that triggers no result is taken while the controller stays idle.
// each result starts its window, then makes one line store read and one sorted
// insert per sample of the window, and is then handed over.
// input is held off while results of a sample are being made or stalled.
// reset is synchronous; the line store is not cleared.
`default_nettype none
module border_clipped_median_filter #(
   parameter int MAX_WIDTH    = bcmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS   = bcmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_CHANNELS = bcmf_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bcmf_req_if.sink                             req_chan,
   bcmf_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bcmf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bcmf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [bcmf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   bcmf_pkg::cmd_type    cmd;
   bcmf_pkg::status_type status;

   assign csr_pready = 1'b1;

   bcmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcmf_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_RADIUS   (MAX_RADIUS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample_in    (req_chan.sample_in),
      .median_value (rsp_chan.median_value),
      .out_row      (rsp_chan.out_row),
      .out_column   (rsp_chan.out_column),
      .out_channel  (rsp_chan.out_channel),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata)
   );

   assign rsp_chan.last_in_run = status.out_last;
endmodule
`default_nettype wire
